// ===== sv/sidlm_pkg.sv =====
`default_nettype none

package sidlm_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int DELAY_DEPTH = 64;
   localparam int PTR_BITS = $clog2(DELAY_DEPTH);

   localparam int FRAC_BITS = 8;
   localparam int DELAY_BITS = 15;
   localparam int WEIGHT_BITS = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;

   localparam int ACC_BITS = SAMPLE_BITS + 34;
   localparam int MUL_A_BITS = (SAMPLE_BITS + 22 > 33) ? SAMPLE_BITS + 22 : 33;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITD_DELAY = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEFT_GAIN = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RIGHT_GAIN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_COEFF = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET_GAIN = 3'd5;

   localparam int STEP_BITS = 5;
   localparam logic [STEP_BITS-1:0] STEP_RD_C0 = 5'd0;
   localparam logic [STEP_BITS-1:0] STEP_RD_C1 = 5'd1;
   localparam logic [STEP_BITS-1:0] STEP_RD_C2 = 5'd2;
   localparam logic [STEP_BITS-1:0] STEP_RD_C3 = 5'd3;
   localparam logic [STEP_BITS-1:0] STEP_TAP_LAST = 5'd4;
   localparam logic [STEP_BITS-1:0] STEP_COMBINE = 5'd5;
   localparam logic [STEP_BITS-1:0] STEP_MUL_C = 5'd6;
   localparam logic [STEP_BITS-1:0] STEP_MUL_B = 5'd7;
   localparam logic [STEP_BITS-1:0] STEP_MUL_A = 5'd8;
   localparam logic [STEP_BITS-1:0] STEP_HERMITE = 5'd9;
   localparam logic [STEP_BITS-1:0] STEP_GAIN = 5'd10;
   localparam logic [STEP_BITS-1:0] STEP_GAIN_SAT = 5'd11;
   localparam logic [STEP_BITS-1:0] STEP_LP1_DIFF = 5'd12;
   localparam logic [STEP_BITS-1:0] STEP_LP1_MUL = 5'd13;
   localparam logic [STEP_BITS-1:0] STEP_LP1_SUM = 5'd14;
   localparam logic [STEP_BITS-1:0] STEP_LP2_DIFF = 5'd15;
   localparam logic [STEP_BITS-1:0] STEP_LP2_MUL = 5'd16;
   localparam logic [STEP_BITS-1:0] STEP_LP2_SUM = 5'd17;
   localparam logic [STEP_BITS-1:0] STEP_WET = 5'd18;
   localparam logic [STEP_BITS-1:0] STEP_DRY = 5'd19;
   localparam logic [STEP_BITS-1:0] STEP_OUT = 5'd20;
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_OUT;

   typedef struct packed {
      logic wr_en;
      logic calc;
      logic [STEP_BITS-1:0] step;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/sidlm_lane.sv =====
`default_nettype none

module sidlm_lane import sidlm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire lane_ctrl_type ctrl,
   input  wire logic [PTR_BITS-1:0] wr_pos,
   input  wire logic [PTR_BITS-1:0] tap_pos,
   input  wire logic [FRAC_BITS-1:0] frac,
   input  wire logic signed [SAMPLE_BITS-1:0] wr_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] dry_sample,
   input  wire logic [WEIGHT_BITS-1:0] gain,
   input  wire logic [WEIGHT_BITS-1:0] coeff,
   input  wire logic [WEIGHT_BITS-1:0] wet,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam int TAP_EXT = SAMPLE_BITS + 4;
   localparam logic signed [ACC_BITS-1:0] SMP_MAX =
      ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_BITS-1:0] SMP_MIN = ~SMP_MAX;
   localparam logic signed [ACC_BITS-1:0] WORD_MAX = ACC_BITS'(64'sd2147483647);
   localparam logic signed [ACC_BITS-1:0] WORD_MIN = ~WORD_MAX;
   localparam logic signed [ACC_BITS-1:0] RND_14 = ACC_BITS'(64'sd8192);
   localparam logic signed [ACC_BITS-1:0] RND_15 = ACC_BITS'(64'sd16384);
   localparam logic signed [ACC_BITS-1:0] RND_16 = ACC_BITS'(64'sd32768);
   localparam logic signed [ACC_BITS-1:0] RND_25 = ACC_BITS'(64'sd16777216);
   localparam logic signed [WEIGHT_BITS:0] UNITY = 17'sd32768;

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_BITS-1:0] v);
      logic signed [SAMPLE_BITS-1:0] r;
      if (v > SMP_MAX) begin
         r = SMP_MAX[SAMPLE_BITS-1:0];
      end else if (v < SMP_MIN) begin
         r = SMP_MIN[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_word(input logic signed [ACC_BITS-1:0] v);
      logic signed [31:0] r;
      if (v > WORD_MAX) begin
         r = WORD_MAX[31:0];
      end else if (v < WORD_MIN) begin
         r = WORD_MIN[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic signed [SAMPLE_BITS-1:0] ring_mem [DELAY_DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic rd_ok_ff;
   logic [PTR_BITS-1:0] rd_addr;
   logic signed [SAMPLE_BITS-1:0] rd_sample;

   logic [DELAY_DEPTH-1:0] valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0] c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic signed [SAMPLE_BITS:0] a_ff, a_in;
   logic signed [TAP_EXT-1:0] b_ff, b_in, cc_ff, cc_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [32:0] d_ff, d_in;
   logic signed [31:0] st1_ff, st1_in, st2_ff, st2_in;
   logic signed [SAMPLE_BITS-1:0] res_ff, res_in;

   logic signed [TAP_EXT-1:0] e0, e1, e2, e3;
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [WEIGHT_BITS:0] mul_b;
   logic signed [WEIGHT_BITS:0] dry_w;
   logic signed [MUL_A_BITS+WEIGHT_BITS:0] prod;
   logic signed [ACC_BITS-1:0] addend;
   logic signed [ACC_BITS-1:0] mac;
   logic signed [31:0] lp_sum;

   assign rd_addr = tap_pos - PTR_BITS'(ctrl.step[1:0]);
   assign rd_sample = rd_ok_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         ring_mem[wr_pos] <= wr_sample;
      end
      rd_data_ff <= ring_mem[rd_addr];
      rd_ok_ff <= valid_ff[rd_addr];
   end

   assign e0 = TAP_EXT'(c0_ff);
   assign e1 = TAP_EXT'(c1_ff);
   assign e2 = TAP_EXT'(c2_ff);
   assign e3 = TAP_EXT'(c3_ff);
   assign dry_w = UNITY - $signed({1'b0, wet});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      addend = '0;
      unique case (ctrl.step)
         STEP_MUL_C: begin
            mul_a = MUL_A_BITS'(cc_ff);
            mul_b = $signed({{(WEIGHT_BITS + 1 - FRAC_BITS){1'b0}}, frac});
            addend = ACC_BITS'(b_ff) <<< 8;
         end
         STEP_MUL_B: begin
            mul_a = acc_ff[MUL_A_BITS-1:0];
            mul_b = $signed({{(WEIGHT_BITS + 1 - FRAC_BITS){1'b0}}, frac});
            addend = ACC_BITS'(a_ff) <<< 16;
         end
         STEP_MUL_A: begin
            mul_a = acc_ff[MUL_A_BITS-1:0];
            mul_b = $signed({{(WEIGHT_BITS + 1 - FRAC_BITS){1'b0}}, frac});
            addend = (ACC_BITS'(c1_ff) <<< 25) + RND_25;
         end
         STEP_GAIN: begin
            mul_a = MUL_A_BITS'(x_ff);
            mul_b = $signed({1'b0, gain});
            addend = RND_14;
         end
         STEP_LP1_MUL, STEP_LP2_MUL: begin
            mul_a = MUL_A_BITS'(d_ff);
            mul_b = $signed({1'b0, coeff});
            addend = RND_16;
         end
         STEP_WET: begin
            mul_a = MUL_A_BITS'(x_ff);
            mul_b = $signed({1'b0, wet});
            addend = RND_15;
         end
         STEP_DRY: begin
            mul_a = MUL_A_BITS'(dry_sample);
            mul_b = dry_w;
            addend = acc_ff;
         end
         default: begin
         end
      endcase
   end

   assign prod = mul_a * mul_b;
   assign mac = $signed(prod[ACC_BITS-1:0]) + addend;
   assign lp_sum = sat_word(ACC_BITS'(x_ff) + (acc_ff >>> 16));

   always_comb begin
      valid_in = valid_ff;
      c0_in = c0_ff;
      c1_in = c1_ff;
      c2_in = c2_ff;
      c3_in = c3_ff;
      a_in = a_ff;
      b_in = b_ff;
      cc_in = cc_ff;
      acc_in = acc_ff;
      x_in = x_ff;
      d_in = d_ff;
      st1_in = st1_ff;
      st2_in = st2_ff;
      res_in = res_ff;
      if (ctrl.wr_en) begin
         valid_in[wr_pos] = 1'b1;
      end
      if (ctrl.calc) begin
         unique case (ctrl.step)
            STEP_RD_C1, STEP_RD_C2, STEP_RD_C3, STEP_TAP_LAST: begin
               c0_in = c1_ff;
               c1_in = c2_ff;
               c2_in = c3_ff;
               c3_in = rd_sample;
            end
            STEP_COMBINE: begin
               a_in = (SAMPLE_BITS + 1)'(c2_ff) - (SAMPLE_BITS + 1)'(c0_ff);
               b_in = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
               cc_in = ((e1 <<< 1) + e1) - e0 - ((e2 <<< 1) + e2) + e3;
            end
            STEP_MUL_C, STEP_MUL_B, STEP_MUL_A, STEP_GAIN,
            STEP_LP1_MUL, STEP_LP2_MUL, STEP_WET, STEP_DRY: begin
               acc_in = mac;
            end
            STEP_HERMITE: begin
               x_in = 32'(sat_sample(acc_ff >>> 25));
            end
            STEP_GAIN_SAT: begin
               x_in = sat_word(acc_ff >>> 14);
            end
            STEP_LP1_DIFF: begin
               d_in = 33'(st1_ff) - 33'(x_ff);
            end
            STEP_LP1_SUM: begin
               st1_in = lp_sum;
               x_in = lp_sum;
            end
            STEP_LP2_DIFF: begin
               d_in = 33'(st2_ff) - 33'(x_ff);
            end
            STEP_LP2_SUM: begin
               st2_in = lp_sum;
               x_in = lp_sum;
            end
            STEP_OUT: begin
               res_in = sat_sample(acc_ff >>> 15);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         st1_ff <= '0;
         st2_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         st1_ff <= st1_in;
         st2_ff <= st2_in;
      end
   end

   always_ff @(posedge clock) begin
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
      c3_ff <= c3_in;
      a_ff <= a_in;
      b_ff <= b_in;
      cc_ff <= cc_in;
      acc_ff <= acc_in;
      x_ff <= x_in;
      d_ff <= d_in;
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ===== sv/stereo_itd_delay_lowpass_mixer_unit.sv =====
`default_nettype none

// Each beat on the request side is one stereo frame. With enable set, the frame is written
// into a 64-entry delay ring per channel, each channel is read back through a 4-point
// Hermite fractional delay (left delayed for a positive interaural delay, right for a
// negative one, the other at zero delay), then scaled by its gain, passed through two
// one-pole lowpass stages and mixed with the dry input, saturated to 24 bits. With enable
// clear, the frame comes back unchanged and no state moves. No new frame is taken until the
// last one has moved into the output register; an enabled frame's processing is set by four
// reads through the read port of each ring and the single multiply-accumulate unit that each
// channel runs through its Hermite, gain, filter and mix steps. The result sits in an output
// register, so the next frame is taken while a result still waits. The rings read as zero
// after reset through per-entry valid bits, so there is no clearing pass. The user must
// write registers only while no frame is in flight; the block itself does not enforce this.
module stereo_itd_delay_lowpass_mixer_unit import sidlm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right_in,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  wire logic csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   function automatic logic [PTR_BITS-1:0] int_part(input logic [DELAY_BITS-1:0] mag);
      logic [PTR_BITS+DELAY_BITS-FRAC_BITS-1:0] ext;
      ext = {{PTR_BITS{1'b0}}, mag[DELAY_BITS-1:FRAC_BITS]};
      return ext[PTR_BITS-1:0];
   endfunction

   logic [1:0] state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic pass_ff, pass_in;
   logic [PTR_BITS-1:0] wp_ff, wp_in;
   logic signed [SAMPLE_BITS-1:0] left_in_ff, left_in_in, right_in_ff, right_in_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;

   logic enable_ff, enable_in;
   logic signed [DELAY_BITS-1:0] itd_ff, itd_in;
   logic [WEIGHT_BITS-1:0] left_gain_ff, left_gain_in, right_gain_ff, right_gain_in;
   logic [WEIGHT_BITS-1:0] coeff_ff, coeff_in, wet_ff, wet_in;

   logic accept;
   logic rsp_free;
   logic finish;
   logic [DELAY_BITS-1:0] left_mag, right_mag;
   logic [PTR_BITS-1:0] left_pos, right_pos;
   logic signed [SAMPLE_BITS-1:0] left_res, right_res;
   lane_ctrl_type lane_ctrl;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign finish = (state_ff == ST_DONE) && rsp_free;

   assign left_mag = (itd_ff > 0) ? DELAY_BITS'(itd_ff) : '0;
   assign right_mag = (itd_ff < 0) ? DELAY_BITS'(-itd_ff) : '0;
   assign left_pos = wp_ff - int_part(left_mag) + PTR_BITS'(1);
   assign right_pos = wp_ff - int_part(right_mag) + PTR_BITS'(1);

   assign lane_ctrl.wr_en = accept && enable_ff;
   assign lane_ctrl.calc = (state_ff == ST_CALC);
   assign lane_ctrl.step = step_ff;

   sidlm_lane u_left (
      .clock(clock),
      .reset(reset),
      .ctrl(lane_ctrl),
      .wr_pos(wp_ff),
      .tap_pos(left_pos),
      .frac(left_mag[FRAC_BITS-1:0]),
      .wr_sample(req_left_in),
      .dry_sample(left_in_ff),
      .gain(left_gain_ff),
      .coeff(coeff_ff),
      .wet(wet_ff),
      .result(left_res)
   );

   sidlm_lane u_right (
      .clock(clock),
      .reset(reset),
      .ctrl(lane_ctrl),
      .wr_pos(wp_ff),
      .tap_pos(right_pos),
      .frac(right_mag[FRAC_BITS-1:0]),
      .wr_sample(req_right_in),
      .dry_sample(right_in_ff),
      .gain(right_gain_ff),
      .coeff(coeff_ff),
      .wet(wet_ff),
      .result(right_res)
   );

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      pass_in = pass_ff;
      wp_in = wp_ff;
      left_in_in = left_in_ff;
      right_in_in = right_in_ff;
      rsp_left_in = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               left_in_in = req_left_in;
               right_in_in = req_right_in;
               pass_in = !enable_ff;
               step_in = STEP_RD_C0;
               state_in = enable_ff ? ST_CALC : ST_DONE;
            end
         end
         ST_CALC: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_left_in = pass_ff ? left_in_ff : left_res;
               rsp_right_in = pass_ff ? right_in_ff : right_res;
               if (!pass_ff) begin
                  wp_in = wp_ff + PTR_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      enable_in = enable_ff;
      itd_in = itd_ff;
      left_gain_in = left_gain_ff;
      right_gain_in = right_gain_ff;
      coeff_in = coeff_ff;
      wet_in = wet_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ENABLE: enable_in = csr_wdata[0];
            CSR_ITD_DELAY: itd_in = $signed(csr_wdata[DELAY_BITS-1:0]);
            CSR_LEFT_GAIN: left_gain_in = csr_wdata;
            CSR_RIGHT_GAIN: right_gain_in = csr_wdata;
            CSR_FILTER_COEFF: coeff_in = csr_wdata;
            CSR_WET_GAIN: wet_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= STEP_RD_C0;
         pass_ff <= 1'b0;
         wp_ff <= '0;
         rsp_valid_ff <= 1'b0;
         enable_ff <= 1'b0;
         itd_ff <= '0;
         left_gain_ff <= WEIGHT_BITS'(8192);
         right_gain_ff <= WEIGHT_BITS'(8192);
         coeff_ff <= '0;
         wet_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         pass_ff <= pass_in;
         wp_ff <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         enable_ff <= enable_in;
         itd_ff <= itd_in;
         left_gain_ff <= left_gain_in;
         right_gain_ff <= right_gain_in;
         coeff_ff <= coeff_in;
         wet_ff <= wet_in;
      end
   end

   always_ff @(posedge clock) begin
      left_in_ff <= left_in_in;
      right_in_ff <= right_in_in;
      rsp_left_ff <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_out = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   // An enabled beat starts the lane sequence at its first ring read.
   assert property (@(posedge clock) disable iff (reset)
      accept && enable_ff |=> (state_ff == ST_CALC) && (step_ff == STEP_RD_C0))
      else $error("enabled beat did not start the lane sequence");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (step_ff <= STEP_LAST))
      else $error("step counter ran past the last step");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared without a finished frame");

   // The write position moves only when an enabled frame hands over its result.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(wp_ff) |-> $past(finish && !pass_ff))
      else $error("write position moved outside an enabled frame completion");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import sidlm_pkg::*;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct {
      sample_type left;
      sample_type right;
   } frame_type;

   localparam sample_type S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam int STALL_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   sample_type req_left_in = '0;
   sample_type req_right_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   sample_type rsp_left_out;
   sample_type rsp_right_out;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Shadow copy of the block's registers and state.
   bit en_m = 1'b0;
   longint delay_m = 0;
   longint gain_m [2] = '{8192, 8192};
   longint coeff_m = 0;
   longint wet_m = 0;
   longint dl_line [2][DELAY_DEPTH];
   longint lp_one [2] = '{0, 0};
   longint lp_two [2] = '{0, 0};
   int wr_ptr = 0;

   frame_type awaited_outputs [$];
   bit send_gaps = 1'b1;
   bit recv_gaps = 1'b1;
   int ready_hold = 0;
   int quiet_cycles = 0;
   int faults = 0;
   int frames_sent = 0;
   int frames_processed = 0;
   int settings_used = 0;

   stereo_itd_delay_lowpass_mixer_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_left_in(req_left_in),
      .req_right_in(req_right_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint clip(input longint x, input int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   function automatic longint round_sh(input longint x, input int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint hermite_tap(input int ch, input longint mag);
      longint n, f, c0, c1, c2, c3, num;
      int idx;
      n = (mag >>> 8) % DELAY_DEPTH;
      f = mag & 255;
      idx = int'((wr_ptr + DELAY_DEPTH - n) % DELAY_DEPTH);
      c0 = dl_line[ch][(idx + 1) % DELAY_DEPTH];
      c1 = dl_line[ch][idx];
      c2 = dl_line[ch][(idx + DELAY_DEPTH - 1) % DELAY_DEPTH];
      c3 = dl_line[ch][(idx + DELAY_DEPTH - 2) % DELAY_DEPTH];
      num = c1 * 33554432 + (c2 - c0) * f * 65536
            + (2 * c0 - 5 * c1 + 4 * c2 - c3) * f * f * 256
            + (c3 - c0 + 3 * c1 - 3 * c2) * f * f * f;
      return clip(round_sh(num, 25), SAMPLE_BITS);
   endfunction

   function automatic longint gain_filter_mix(input int ch, input longint h, input longint dry);
      longint g, y;
      g = clip(round_sh(h * gain_m[ch], 14), 32);
      y = clip(g + round_sh(coeff_m * (lp_one[ch] - g), 16), 32);
      lp_one[ch] = y;
      y = clip(y + round_sh(coeff_m * (lp_two[ch] - y), 16), 32);
      lp_two[ch] = y;
      return clip(round_sh(y * wet_m + dry * (32768 - wet_m), 15), SAMPLE_BITS);
   endfunction

   function automatic frame_type itd_mix_frame(input sample_type l, input sample_type r);
      frame_type res;
      longint lmag, rmag, lo, ro;
      if (!en_m) begin
         res.left = l;
         res.right = r;
         return res;
      end
      frames_processed++;
      dl_line[0][wr_ptr] = longint'(l);
      dl_line[1][wr_ptr] = longint'(r);
      lmag = (delay_m > 0) ? delay_m : 0;
      rmag = (delay_m < 0) ? -delay_m : 0;
      lo = gain_filter_mix(0, hermite_tap(0, lmag), longint'(l));
      ro = gain_filter_mix(1, hermite_tap(1, rmag), longint'(r));
      res.left = lo[SAMPLE_BITS-1:0];
      res.right = ro[SAMPLE_BITS-1:0];
      wr_ptr = (wr_ptr + 1) % DELAY_DEPTH;
      return res;
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 7))
         0: return S_MAX;
         1: return S_MIN;
         2: return sample_type'(int'($urandom_range(0, 4095)) - 2048);
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic send_frame(input sample_type l, input sample_type r);
      int gap;
      gap = send_gaps ? $urandom_range(0, 18) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_left_in <= l;
      req_right_in <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_outputs.push_back(itd_mix_frame(l, r));
      frames_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_ENABLE: en_m = data[0];
         CSR_ITD_DELAY: delay_m = longint'($signed(data[DELAY_BITS-1:0]));
         CSR_LEFT_GAIN: gain_m[0] = longint'(data);
         CSR_RIGHT_GAIN: gain_m[1] = longint'(data);
         CSR_FILTER_COEFF: coeff_m = longint'(data);
         CSR_WET_GAIN: wet_m = longint'(data);
         default: ;
      endcase
   endtask

   task automatic program_all(input bit en, input longint d, input longint lg,
                              input longint rg, input longint co, input longint wt);
      settle();
      write_reg(CSR_ENABLE, {15'b0, en});
      write_reg(CSR_ITD_DELAY, {1'b0, d[DELAY_BITS-1:0]});
      write_reg(CSR_LEFT_GAIN, lg[15:0]);
      write_reg(CSR_RIGHT_GAIN, rg[15:0]);
      write_reg(CSR_FILTER_COEFF, co[15:0]);
      write_reg(CSR_WET_GAIN, wt[15:0]);
      settings_used++;
   endtask

   task automatic note_fault(input string msg);
      faults++;
      if (faults <= 10) $display("%t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : result_side
      frame_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         if (awaited_outputs.size() == 0) begin
            note_fault("result beat with no frame outstanding");
         end else begin
            want = awaited_outputs.pop_front();
            if (rsp_left_out !== want.left)
               note_fault($sformatf("left_out expected %0d, got %0d", want.left, rsp_left_out));
            if (rsp_right_out !== want.right)
               note_fault($sformatf("right_out expected %0d, got %0d", want.right,
                                    rsp_right_out));
         end
         ready_hold = recv_gaps ? $urandom_range(0, 18) : 0;
         if (ready_hold != 0) rsp_ready <= 1'b0;
      end else if (!rsp_ready) begin
         if (ready_hold > 0) ready_hold--;
         else rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no beat accepted for %0d cycles.", STALL_LIMIT);
         $display("stereo_itd_delay_lowpass_mixer_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Reset defaults leave the block disabled, so frames come straight back.
   task automatic test_bypass();
      send_frame(S_MAX, S_MIN);
      send_frame(S_MIN, S_MAX);
      send_frame('0, '1);
   endtask

   task automatic test_integer_delay();
      program_all(1'b1, 3 * 256, 16384, 16384, 0, 32768);
      send_frame(sample_type'(24'h100000), sample_type'(-24'sh100000));
      repeat (4) send_frame('0, '0);
   endtask

   task automatic test_fractional_delay();
      program_all(1'b1, 384, 20000, 12000, 30000, 24576);
      repeat (4) send_frame(rand_sample(), rand_sample());
      program_all(1'b1, -640, 9000, 30000, 50000, 32768);
      repeat (4) send_frame(rand_sample(), rand_sample());
   endtask

   // Oversized gains and wet weight drive the output into saturation; the
   // most negative delay has an integer part that wraps around the ring.
   task automatic test_saturation_and_wrap();
      program_all(1'b1, 16383, 65535, 65535, 65535, 65535);
      send_frame(S_MAX, S_MIN);
      send_frame(S_MIN, S_MAX);
      send_frame(S_MAX, S_MAX);
      program_all(1'b1, -16384, 8192, 65535, 0, 32768);
      send_frame(S_MIN, S_MIN);
      send_frame(S_MAX, S_MIN);
      send_frame('0, S_MAX);
   endtask

   task automatic test_random_sweep();
      bit en;
      longint d, lg, rg, co, wt;
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 0) begin
            en = 1'b1; d = -8192; lg = 0; rg = 0; co = 0; wt = 0;
         end else if (ph == 1) begin
            en = 1'b1; d = 8192; lg = 32768; rg = 32768; co = 65535; wt = 32768;
         end else begin
            en = ($urandom_range(0, 5) != 0);
            if ($urandom_range(0, 4) == 0) d = longint'(int'($urandom_range(0, 32767)) - 16384);
            else d = longint'(int'($urandom_range(0, 16384)) - 8192);
            lg = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(32769, 65535))
                                             : longint'($urandom_range(0, 32768));
            rg = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(32769, 65535))
                                             : longint'($urandom_range(0, 32768));
            co = longint'($urandom_range(0, 65535));
            wt = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(32769, 65535))
                                             : longint'($urandom_range(0, 32768));
         end
         send_gaps = ($urandom_range(0, 3) != 0);
         recv_gaps = ($urandom_range(0, 3) != 0);
         program_all(en, d, lg, rg, co, wt);
         repeat (104) begin
            if ($urandom_range(0, 79) == 0) settle();
            send_frame(rand_sample(), rand_sample());
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bypass();
      test_integer_delay();
      test_fractional_delay();
      test_saturation_and_wrap();
      test_random_sweep();
      settle();
      repeat (30) @(posedge clock);
      $display("Sent %0d frames, %0d through the delay, filter and mix path, the rest bypassed.",
               frames_sent, frames_processed);
      $display("Register settings applied: %0d; faults counted: %0d.", settings_used, faults);
      if (faults == 0) begin
         $display("stereo_itd_delay_lowpass_mixer_unit: match");
      end else begin
         $display("stereo_itd_delay_lowpass_mixer_unit: mismatch");
      end
      $finish;
   end

endmodule
